[hw/rtl/lcdseq_pkg.sv]
// Shared types, constants and command tables for the character LCD nibble sequencer.
`timescale 1ns / 1ps

package lcdseq_pkg;

  typedef enum logic [1:0] {
    KIND_INIT   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_CURSOR = 2'd3
  } kind_e;

  localparam logic [7:0] POWER_UP_HOLD   = 8'd150;
  localparam logic [7:0] ADDR_CMD_BASE   = 8'h80;
  localparam logic [2:0] PHASE_FINAL     = 3'd5;
  localparam logic [2:0] PHASE_HI_SETUP  = 3'd0;
  localparam logic [2:0] PHASE_HI_STROBE = 3'd1;
  localparam logic [2:0] PHASE_HI_HOLD   = 3'd2;
  localparam logic [2:0] PHASE_LO_SETUP  = 3'd3;
  localparam logic [2:0] PHASE_LO_STROBE = 3'd4;
  localparam logic [2:0] INIT_CURSOR_IDX = 3'd6;
  localparam logic [7:0] STROBE_HOLD     = 8'd1;
  localparam logic [7:0] RELEASE_HOLD    = 8'd2;
  localparam logic [7:0] SAT_HOLD        = 8'd255;

  // One request as held in the request register.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       row;
    logic [5:0] col;
    logic [7:0] extra_hold;
  } req_t;

  // Position within the pin-state run of the current request.
  typedef struct packed {
    logic       pre;       // power-up wait state of an initialise run
    logic [2:0] byte_idx;
    logic [2:0] phase;
  } seq_pos_t;

  typedef struct packed {
    logic       rs_level;
    logic       en_level;
    logic [3:0] data_nibble;
    logic [7:0] hold_units;
    logic       last;
  } pin_state_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      3'd0:    cmd = 8'h33;
      3'd1:    cmd = 8'h32;
      3'd2:    cmd = 8'h28;
      3'd3:    cmd = 8'h0F;
      3'd4:    cmd = 8'h01;
      3'd5:    cmd = 8'h06;
      default: cmd = ADDR_CMD_BASE;
    endcase
    return cmd;
  endfunction

  function automatic logic [7:0] init_wait(input logic [2:0] idx);
    logic [7:0] w;
    unique case (idx)
      3'd0:    w = 8'd50;
      3'd4:    w = 8'd20;
      default: w = 8'd1;
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/char_lcd_nibble_sequencer_top.sv]
// Top level of the character LCD nibble sequencer: request register, run counter, output register.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid_i / in_stall_o) carries one request: initialise,
// command byte, data byte or set cursor. The output channel (out_valid_o /
// out_stall_i) carries the resulting pin states for a 4-bit character LCD, one
// per transfer, with last marking the final state of a run.
// A request is held in a request register while a position counter walks its
// run; each cycle one pin state is formed and loaded into the output register,
// unless the output stalls. A request passes the request register and then the
// output register; a byte write is a run of 6 pin states and an initialise 43.
// The next request is taken in the same cycle the last pin state of the current
// run is loaded, so runs follow without gaps.
// When the receiver stalls, the output register holds its state and the run
// pauses; the input side stalls while a run is still being expanded.
// Reset clears the request and output valid flags; no request is in flight
// and nothing is presented on the output after reset.
module char_lcd_nibble_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] value_i,
  input  logic       row_i,
  input  logic [5:0] col_i,
  input  logic [7:0] extra_hold_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       rs_level_o,
  output logic       en_level_o,
  output logic [3:0] data_nibble_o,
  output logic [7:0] hold_units_o,
  output logic       last_o
);

  lcdseq_pkg::req_t       req_q, req_d;
  lcdseq_pkg::seq_pos_t   pos_q, pos_d;
  lcdseq_pkg::pin_state_t pin;
  lcdseq_pkg::pin_state_t out_q, out_d;
  logic                   req_valid_q, req_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic                   load_out;
  logic                   in_take;

  lcdseq_gen u_gen (
    .req_i (req_q),
    .pos_i (pos_q),
    .pin_o (pin)
  );

  assign load_out   = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !(load_out && pin.last);
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    req_valid_d = req_valid_q;
    req_d       = req_q;
    pos_d       = pos_q;
    if (load_out) begin
      if (pos_q.pre) begin
        pos_d.pre      = 1'b0;
        pos_d.byte_idx = 3'd0;
        pos_d.phase    = 3'd0;
      end else if (pos_q.phase == lcdseq_pkg::PHASE_FINAL) begin
        pos_d.phase    = 3'd0;
        pos_d.byte_idx = pos_q.byte_idx + 3'd1;
      end else begin
        pos_d.phase = pos_q.phase + 3'd1;
      end
      if (pin.last) begin
        req_valid_d = 1'b0;
      end
    end
    if (in_take) begin
      req_valid_d       = 1'b1;
      req_d.kind        = lcdseq_pkg::kind_e'(kind_i);
      req_d.value       = value_i;
      req_d.row         = row_i;
      req_d.col         = col_i;
      req_d.extra_hold  = extra_hold_i;
      pos_d.pre         = (lcdseq_pkg::kind_e'(kind_i) == lcdseq_pkg::KIND_INIT);
      pos_d.byte_idx    = 3'd0;
      pos_d.phase       = 3'd0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_d       = pin;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign rs_level_o    = out_q.rs_level;
  assign en_level_o    = out_q.en_level;
  assign data_nibble_o = out_q.data_nibble;
  assign hold_units_o  = out_q.hold_units;
  assign last_o        = out_q.last;

endmodule

[hw/rtl/lcdseq_gen.sv]
// Pin-state generator: maps a held request and a run position to one LCD pin state.
`timescale 1ns / 1ps

module lcdseq_gen (
  input  lcdseq_pkg::req_t       req_i,
  input  lcdseq_pkg::seq_pos_t   pos_i,
  output lcdseq_pkg::pin_state_t pin_o
);

  logic [7:0] byte_val;
  logic       rs;
  logic [8:0] tail;
  logic [9:0] final_sum;
  logic [7:0] final_hold;
  logic [3:0] nibble;
  logic       run_end;

  always_comb begin
    rs   = 1'b0;
    byte_val = req_i.value;
    tail = {1'b0, req_i.extra_hold};
    unique case (req_i.kind)
      lcdseq_pkg::KIND_INIT: begin
        byte_val = lcdseq_pkg::init_cmd(pos_i.byte_idx);
        tail     = {1'b0, lcdseq_pkg::init_wait(pos_i.byte_idx)};
      end
      lcdseq_pkg::KIND_CMD: begin
        rs = 1'b0;
      end
      lcdseq_pkg::KIND_DATA: begin
        rs = 1'b1;
      end
      lcdseq_pkg::KIND_CURSOR: begin
        // Address byte: bit 7 set, bit 6 selects the second line.
        byte_val = {1'b1, req_i.row, req_i.col};
        tail     = {1'b0, req_i.extra_hold} + 9'd1;
      end
      default: begin
        rs = 1'b0;
      end
    endcase
  end

  assign final_sum  = {2'b00, lcdseq_pkg::RELEASE_HOLD} + {1'b0, tail};
  assign final_hold = (final_sum > {2'b00, lcdseq_pkg::SAT_HOLD}) ?
                      lcdseq_pkg::SAT_HOLD : final_sum[7:0];
  assign nibble     = (pos_i.phase < lcdseq_pkg::PHASE_LO_SETUP) ?
                      byte_val[7:4] : byte_val[3:0];
  assign run_end    = (pos_i.phase == lcdseq_pkg::PHASE_FINAL) &&
                      ((req_i.kind != lcdseq_pkg::KIND_INIT) ||
                       (pos_i.byte_idx == lcdseq_pkg::INIT_CURSOR_IDX));

  always_comb begin
    pin_o.rs_level    = rs;
    pin_o.en_level    = 1'b0;
    pin_o.data_nibble = nibble;
    pin_o.hold_units  = 8'd0;
    pin_o.last        = run_end;
    if (pos_i.pre) begin
      pin_o.rs_level    = 1'b0;
      pin_o.data_nibble = 4'd0;
      pin_o.hold_units  = lcdseq_pkg::POWER_UP_HOLD;
      pin_o.last        = 1'b0;
    end else begin
      unique case (pos_i.phase)
        lcdseq_pkg::PHASE_HI_STROBE,
        lcdseq_pkg::PHASE_LO_STROBE: begin
          pin_o.en_level   = 1'b1;
          pin_o.hold_units = lcdseq_pkg::STROBE_HOLD;
        end
        lcdseq_pkg::PHASE_HI_HOLD: begin
          pin_o.hold_units = lcdseq_pkg::RELEASE_HOLD;
        end
        lcdseq_pkg::PHASE_FINAL: begin
          pin_o.hold_units = final_hold;
        end
        default: begin
          pin_o.hold_units = 8'd0;
        end
      endcase
    end
  end

endmodule
